[hdl/ect_pkg.sv]
// Shared types, codes and default sizes for the epoch completion tracker.
// Used by every module of the block and by its checker; depends on nothing.
package ect_pkg;

   localparam int NUM_DOMAINS_DEFAULT    = 16;
   localparam int REORDER_WINDOW_DEFAULT = 64;
   localparam int DOMAIN_CODES           = 16;
   localparam int VALUE_W                = 32;
   localparam int QUEUE_DEPTH            = 2;
   localparam int QPTR_W                 = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] CMD_COMPLETE = 2'd0;
   localparam logic [1:0] CMD_CHECK    = 2'd1;
   localparam logic [1:0] CMD_CLOSE    = 2'd2;

   localparam logic [2:0] STATUS_ADVANCED = 3'd0;
   localparam logic [2:0] STATUS_PENDING  = 3'd1;
   localparam logic [2:0] STATUS_STALE    = 3'd2;
   localparam logic [2:0] STATUS_DROPPED  = 3'd3;
   localparam logic [2:0] STATUS_MET      = 3'd4;
   localparam logic [2:0] STATUS_NOT_MET  = 3'd5;
   localparam logic [2:0] STATUS_CLOSED   = 3'd6;

   typedef enum logic [1:0] {
      OP_COMPLETE,
      OP_CHECK,
      OP_CLOSE,
      OP_IGNORE
   } op_type;

   typedef enum logic [1:0] {
      SEQ_READ,
      SEQ_SCAN,
      SEQ_WRITE
   } seq_state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [3:0]         domain;
      logic [VALUE_W-1:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [VALUE_W-1:0] completed;
      logic               all_met;
      logic               is_closed;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic [3:0]         domain;
      logic [VALUE_W-1:0] value;
      logic               last;
   } task_type;

endpackage

[hdl/ect_front.sv]
// Front end of the epoch completion tracker: accepts request beats, decodes the
// command and holds the decoded tasks in a short queue. Depends on ect_pkg.
module ect_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ect_pkg::req_type  req_data,
   output logic              task_valid,
   input  logic              task_pop,
   output ect_pkg::task_type task_data
);

   ect_pkg::task_type                 entry;
   ect_pkg::task_type                 queue_mem [ect_pkg::QUEUE_DEPTH];
   logic [ect_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [ect_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [ect_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [ect_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [ect_pkg::QPTR_W:0]          fill_ff;
   logic [ect_pkg::QPTR_W:0]          fill_in;
   logic                              push;
   logic                              pop;

   always_comb begin
      entry.domain = req_data.domain;
      entry.value  = req_data.value;
      entry.last   = req_data.last;
      case (req_data.cmd)
         ect_pkg::CMD_COMPLETE: entry.op = ect_pkg::OP_COMPLETE;
         ect_pkg::CMD_CHECK:    entry.op = ect_pkg::OP_CHECK;
         ect_pkg::CMD_CLOSE:    entry.op = ect_pkg::OP_CLOSE;
         default:               entry.op = ect_pkg::OP_IGNORE;
      endcase
   end

   assign req_stall  = (fill_ff == (ect_pkg::QPTR_W+1)'(ect_pkg::QUEUE_DEPTH));
   assign task_valid = (fill_ff != '0);
   assign task_data  = queue_mem[rd_ptr_ff];
   assign push       = req_valid && !req_stall;
   assign pop        = task_pop && task_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (ect_pkg::QPTR_W+1)'(push) - (ect_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= entry;
      end
   end

endmodule

[hdl/ect_back.sv]
// Back end of the epoch completion tracker: per-domain count and pending-window
// store, read-scan-write sequencer and result register. Depends on ect_pkg.
module ect_back #(
   parameter int NUM_DOMAINS    = ect_pkg::NUM_DOMAINS_DEFAULT,
   parameter int REORDER_WINDOW = ect_pkg::REORDER_WINDOW_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              task_valid,
   output logic              task_pop,
   input  ect_pkg::task_type task_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ect_pkg::rsp_type  rsp_data
);

   localparam int DOM_W = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;
   localparam int RUN_W = $clog2(REORDER_WINDOW + 1);
   localparam int POS_W = (REORDER_WINDOW > 1) ? $clog2(REORDER_WINDOW) : 1;
   localparam int VW    = ect_pkg::VALUE_W;

   ect_pkg::seq_state_type    state_ff;
   ect_pkg::seq_state_type    state_in;
   logic                      issue_read;
   logic                      do_finish;
   logic                      out_free;

   logic [DOM_W-1:0]          dom_map [ect_pkg::DOMAIN_CODES];
   logic [VW-1:0]             count_mem [NUM_DOMAINS];
   logic [REORDER_WINDOW-1:0] pend_mem [NUM_DOMAINS];
   logic [NUM_DOMAINS-1:0]    valid_ff;

   ect_pkg::task_type         cur_ff;
   logic [DOM_W-1:0]          addr_ff;
   logic [VW-1:0]             rd_count_ff;
   logic [REORDER_WINDOW-1:0] rd_pend_ff;
   logic                      rd_valid_ff;

   logic [VW-1:0]             eff_count;
   logic [REORDER_WINDOW-1:0] eff_pend;
   logic [REORDER_WINDOW-1:0] scan_bits;
   logic [VW-1:0]             diff;
   logic [VW-1:0]             diff_m1;
   logic [RUN_W-1:0]          run_len;
   logic [2:0]                scan_status;

   logic [2:0]                status_ff;
   logic [RUN_W-1:0]          run_ff;
   logic [POS_W-1:0]          pos_ff;

   logic                      closed_ff;
   logic                      closed_in;
   logic                      run_met_ff;
   logic                      run_met_in;
   logic                      all_met;
   logic                      write_en;
   logic [VW-1:0]             new_count;
   logic [REORDER_WINDOW-1:0] new_pend;

   logic                      out_valid_ff;
   logic                      out_valid_in;
   ect_pkg::rsp_type          out_data_ff;
   ect_pkg::rsp_type          out_data_in;

   for (genvar i = 0; i < ect_pkg::DOMAIN_CODES; i++) begin : g_dom_map
      assign dom_map[i] = DOM_W'(i % NUM_DOMAINS);
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      case (state_ff)
         ect_pkg::SEQ_READ:  state_in = task_valid ? ect_pkg::SEQ_SCAN : ect_pkg::SEQ_READ;
         ect_pkg::SEQ_SCAN:  state_in = ect_pkg::SEQ_WRITE;
         ect_pkg::SEQ_WRITE: state_in = out_free ? ect_pkg::SEQ_READ : ect_pkg::SEQ_WRITE;
         default:            state_in = ect_pkg::SEQ_READ;
      endcase
   end

   always_comb begin
      issue_read = 1'b0;
      do_finish  = 1'b0;
      case (state_ff)
         ect_pkg::SEQ_READ:  issue_read = task_valid;
         ect_pkg::SEQ_WRITE: do_finish  = out_free;
         default: begin
            issue_read = 1'b0;
            do_finish  = 1'b0;
         end
      endcase
   end

   assign task_pop = issue_read;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ect_pkg::SEQ_READ;
      end else begin
         state_ff <= state_in;
      end
   end

   // Store read: the entry of an unwritten domain reads as zero.
   always_ff @(posedge clock) begin
      if (issue_read) begin
         cur_ff      <= task_data;
         addr_ff     <= dom_map[task_data.domain];
         rd_count_ff <= count_mem[dom_map[task_data.domain]];
         rd_pend_ff  <= pend_mem[dom_map[task_data.domain]];
         rd_valid_ff <= valid_ff[dom_map[task_data.domain]];
      end
   end

   always_comb begin
      eff_count = rd_valid_ff ? rd_count_ff : '0;
      eff_pend  = rd_valid_ff ? rd_pend_ff : '0;
      scan_bits = eff_pend | REORDER_WINDOW'(1);
      diff      = cur_ff.value - eff_count;
      diff_m1   = diff - VW'(1);
   end

   // Length of the run of consecutive finished epochs from the next one on.
   always_comb begin
      run_len = RUN_W'(REORDER_WINDOW);
      for (int i = REORDER_WINDOW - 1; i >= 0; i--) begin
         if (!scan_bits[i]) begin
            run_len = RUN_W'(i);
         end
      end
   end

   always_comb begin
      case (cur_ff.op)
         ect_pkg::OP_COMPLETE: begin
            if (cur_ff.value <= eff_count) begin
               scan_status = ect_pkg::STATUS_STALE;
            end else if (diff > VW'(REORDER_WINDOW)) begin
               scan_status = ect_pkg::STATUS_DROPPED;
            end else if (diff == VW'(1)) begin
               scan_status = ect_pkg::STATUS_ADVANCED;
            end else begin
               scan_status = ect_pkg::STATUS_PENDING;
            end
         end
         ect_pkg::OP_CHECK: begin
            if (closed_ff) begin
               scan_status = ect_pkg::STATUS_CLOSED;
            end else if (eff_count >= cur_ff.value) begin
               scan_status = ect_pkg::STATUS_MET;
            end else begin
               scan_status = ect_pkg::STATUS_NOT_MET;
            end
         end
         ect_pkg::OP_CLOSE: scan_status = ect_pkg::STATUS_CLOSED;
         default:           scan_status = ect_pkg::STATUS_STALE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ect_pkg::SEQ_SCAN) begin
         status_ff <= scan_status;
         run_ff    <= run_len;
         pos_ff    <= diff_m1[POS_W-1:0];
      end
   end

   always_comb begin
      new_count = eff_count;
      new_pend  = eff_pend;
      write_en  = 1'b0;
      case (status_ff)
         ect_pkg::STATUS_ADVANCED: begin
            new_count = eff_count + VW'(run_ff);
            new_pend  = eff_pend >> run_ff;
            write_en  = 1'b1;
         end
         ect_pkg::STATUS_PENDING: begin
            new_pend[pos_ff] = 1'b1;
            write_en         = 1'b1;
         end
         default: begin
            write_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      closed_in  = closed_ff;
      run_met_in = run_met_ff;
      all_met    = run_met_ff;
      case (cur_ff.op)
         ect_pkg::OP_CHECK: begin
            all_met    = run_met_ff && (status_ff == ect_pkg::STATUS_MET);
            run_met_in = cur_ff.last ? 1'b1 : all_met;
         end
         ect_pkg::OP_CLOSE: closed_in = 1'b1;
         default:           closed_in = closed_ff;
      endcase
      out_data_in.status    = status_ff;
      out_data_in.completed = new_count;
      out_data_in.all_met   = all_met;
      out_data_in.is_closed = closed_in;
      out_valid_in          = do_finish ? 1'b1 : (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (do_finish && write_en) begin
         count_mem[addr_ff] <= new_count;
         pend_mem[addr_ff]  <= new_pend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         closed_ff    <= 1'b0;
         run_met_ff   <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (do_finish) begin
            closed_ff  <= closed_in;
            run_met_ff <= run_met_in;
            if (write_en) begin
               valid_ff[addr_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_finish) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[hdl/epoch_completion_tracker_unit.sv]
// Top level of the epoch completion tracker: joins the decoding front end and
// the per-domain back end through the task queue. Depends on ect_pkg.
//
// Each request beat carries a command (complete, check or close), an ordering
// domain, an epoch value and a last flag; each one yields exactly one response
// beat with a status code, the domain's contiguous completed count, the
// running AND of the current check run and the sticky closed flag.
// A completion one past the count advances it over every epoch already held
// early in the domain's reorder window; one further ahead inside the window is
// held, one beyond it is dropped, one at or below the count is ignored.
// Both channels use valid and stall. The front end queues up to two decoded
// beats, so requests are taken while the back end works or a response waits.
// The back end handles each beat as a registered read of the domain's count
// and window, a scan for the run of finished epochs, then the write-back and
// loading of the response register. It finishes one beat before it reads the
// next, as this read-modify-write of the domain store requires.
// A stalled response holds the back end in its write step; the queue fills and
// then stalls the request channel. Reset empties the queue and the response
// register, marks every domain as count zero with an empty window, clears the
// closed flag and starts a fresh check run; no beat is lost across a stall.
module epoch_completion_tracker_unit #(
   parameter int NUM_DOMAINS    = ect_pkg::NUM_DOMAINS_DEFAULT,
   parameter int REORDER_WINDOW = ect_pkg::REORDER_WINDOW_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ect_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ect_pkg::rsp_type rsp_data
);

   logic              task_valid;
   logic              task_pop;
   ect_pkg::task_type task_data;

   ect_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .task_valid (task_valid),
      .task_pop   (task_pop),
      .task_data  (task_data)
   );

   ect_back #(
      .NUM_DOMAINS    (NUM_DOMAINS),
      .REORDER_WINDOW (REORDER_WINDOW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .task_valid (task_valid),
      .task_pop   (task_pop),
      .task_data  (task_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

[hdl/ect_checker.sv]
// Port-level checker for the epoch completion tracker and its bind to the top
// level. Depends on ect_pkg and epoch_completion_tracker_unit.
module ect_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ect_pkg::rsp_type rsp_data
);

   logic [3:0] outstanding_ff;
   logic [3:0] outstanding_in;
   logic       seen_closed_ff;
   logic       seen_closed_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   always_comb begin
      outstanding_in = outstanding_ff + 4'(req_beat) - 4'(rsp_beat);
      seen_closed_in = seen_closed_ff || (rsp_beat && rsp_data.is_closed);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         seen_closed_ff <= 1'b0;
      end else begin
         outstanding_ff <= outstanding_in;
         seen_closed_ff <= seen_closed_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response beat changed or was withdrawn.");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 4'd0)
      else $error("Response beat offered without an outstanding request beat.");

   a_closed_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_closed_ff |-> rsp_data.is_closed)
      else $error("Closed flag dropped after a closed response beat.");

   a_closed_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ect_pkg::STATUS_CLOSED |-> rsp_data.is_closed)
      else $error("Closed status reported while the closed flag is clear.");

   a_met_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ect_pkg::STATUS_MET |-> !rsp_data.is_closed)
      else $error("Check reported met after the tracker was closed.");

endmodule

bind epoch_completion_tracker_unit ect_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[bench/tb_epoch_completion_tracker_unit.sv]
`timescale 1ns / 1ps
// Self-checking bench for epoch_completion_tracker_unit: a queue-fed bursty driver, a stalling
// receiver and a monitor that predicts every response beat from its own copy of the per-domain
// counts and reorder windows. Depends on ect_pkg and the RTL only.
module tb_epoch_completion_tracker_unit;

   localparam int DOMAINS = ect_pkg::NUM_DOMAINS_DEFAULT;
   localparam int WINDOW = ect_pkg::REORDER_WINDOW_DEFAULT;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int GEN = 0;
   localparam int LIVE = 1;
   localparam int RANDOM_BEATS = 1850;

   typedef struct packed {
      logic pause;
      ect_pkg::req_type beat;
   } feed_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ect_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ect_pkg::rsp_type rsp_data;

   feed_item_type feed_q[$];
   feed_item_type head;
   ect_pkg::rsp_type expected_q[$];
   ect_pkg::rsp_type want;
   int total_n = 0;
   int accepted_n = 0;
   int returned_n = 0;
   int mismatches = 0;

   logic [31:0] done_cnt [2][DOMAINS];
   logic [63:0] early [2][DOMAINS];
   logic closed_seen [2];
   logic run_ok [2];

   int gap_left = 0;
   int burst_left = 0;
   bit holding = 1'b0;
   int stall_left = 0;
   int free_left = 8;

   epoch_completion_tracker_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic ect_pkg::rsp_type track_step(input int sel, input ect_pkg::req_type r);
      ect_pkg::rsp_type o;
      int dom;
      int n;
      logic [31:0] c;
      logic [31:0] d;
      logic [63:0] bits;
      logic met;
      o = '0;
      dom = int'(r.domain) % DOMAINS;
      c = done_cnt[sel][dom];
      o.status = ect_pkg::STATUS_STALE;
      o.all_met = run_ok[sel];
      case (r.cmd)
         ect_pkg::CMD_COMPLETE: begin
            d = r.value - c;
            if (r.value <= c) begin
               o.status = ect_pkg::STATUS_STALE;
            end else if (d > WINDOW) begin
               o.status = ect_pkg::STATUS_DROPPED;
            end else if (d >= 2) begin
               early[sel][dom][d - 1] = 1'b1;
               o.status = ect_pkg::STATUS_PENDING;
            end else begin
               bits = early[sel][dom] | 64'd1;
               n = 0;
               while (n < 64 && bits[n]) n++;
               done_cnt[sel][dom] = c + 32'(n);
               early[sel][dom] = (n >= 64) ? 64'd0 : bits >> n;
               o.status = ect_pkg::STATUS_ADVANCED;
            end
         end
         ect_pkg::CMD_CHECK: begin
            if (closed_seen[sel]) begin
               met = 1'b0;
               o.status = ect_pkg::STATUS_CLOSED;
            end else begin
               met = (c >= r.value);
               o.status = met ? ect_pkg::STATUS_MET : ect_pkg::STATUS_NOT_MET;
            end
            o.all_met = run_ok[sel] & met;
            run_ok[sel] = r.last ? 1'b1 : o.all_met;
         end
         ect_pkg::CMD_CLOSE: begin
            closed_seen[sel] = 1'b1;
            o.status = ect_pkg::STATUS_CLOSED;
         end
         default: ;
      endcase
      o.completed = done_cnt[sel][dom];
      o.is_closed = closed_seen[sel];
      return o;
   endfunction

   function automatic void queue_beat(input logic [1:0] cmd, input int dom,
                                      input logic [31:0] value, input logic last);
      feed_item_type f;
      f.pause = 1'b0;
      f.beat.cmd = cmd;
      f.beat.domain = 4'(dom);
      f.beat.value = value;
      f.beat.last = last;
      feed_q.insert(feed_q.size(), f);
      void'(track_step(GEN, f.beat));
      total_n++;
   endfunction

   function automatic void queue_pause();
      feed_item_type f;
      f = '0;
      f.pause = 1'b1;
      feed_q.insert(feed_q.size(), f);
   endfunction

   function automatic logic [31:0] check_value(input int dom);
      logic [31:0] c;
      c = done_cnt[GEN][dom];
      case ($urandom_range(0, 4))
         0: return c;
         1: return (c > 3) ? c - 3 : 32'd0;
         2: return c + 1;
         3: return c + 32'($urandom_range(2, 40));
         default: return $urandom();
      endcase
   endfunction

   function automatic void queue_random_beat();
      int dom;
      int r;
      int k;
      logic [31:0] c;
      dom = $urandom_range(0, DOMAINS - 1);
      r = $urandom_range(0, 99);
      c = done_cnt[GEN][dom];
      k = $urandom_range(0, 8);
      if (r < 28)
         queue_beat(ect_pkg::CMD_COMPLETE, dom, c + 1, 1'($urandom_range(0, 1)));
      else if (r < 42)
         queue_beat(ect_pkg::CMD_COMPLETE, dom, c + 32'($urandom_range(2, WINDOW)),
                    1'($urandom_range(0, 1)));
      else if (r < 48)
         queue_beat(ect_pkg::CMD_COMPLETE, dom, (c >= k) ? c - k : 32'd0,
                    1'($urandom_range(0, 1)));
      else if (r < 53)
         queue_beat(ect_pkg::CMD_COMPLETE, dom, c + 32'($urandom_range(WINDOW + 1, 300)),
                    1'b0);
      else if (r < 57)
         queue_beat(ect_pkg::CMD_COMPLETE, dom, $urandom(), 1'($urandom_range(0, 1)));
      else if (r < 96)
         queue_beat(ect_pkg::CMD_CHECK, dom, check_value(dom), $urandom_range(0, 2) == 0);
      else
         queue_beat(CMD_UNUSED, dom, $urandom(), 1'($urandom_range(0, 1)));
   endfunction

   task automatic check_field(input string name, input logic [31:0] expd, input logic [31:0] got);
      if (expd !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expd, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (holding) begin
            if (accepted_n == returned_n) holding = 1'b0;
         end else if (feed_q.size() != 0 && feed_q[0].pause) begin
            void'(feed_q.pop_front());
            holding = 1'b1;
         end
         if (holding || gap_left != 0 || feed_q.size() == 0 || feed_q[0].pause) begin
            if (!holding && gap_left != 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            head = feed_q.pop_front();
            req_data <= head.beat;
            req_valid <= 1'b1;
            if (burst_left != 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left != 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_left = $urandom_range(0, 5);
         free_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            returned_n <= returned_n + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: response beat with none expected, expected nothing, actual %0h",
                        $time, rsp_data);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("completed", want.completed, rsp_data.completed);
               check_field("all_met", 32'(want.all_met), 32'(rsp_data.all_met));
               check_field("is_closed", 32'(want.is_closed), 32'(rsp_data.is_closed));
            end
         end
         if (req_valid && !req_stall) begin
            expected_q.insert(expected_q.size(), track_step(LIVE, req_data));
            accepted_n <= accepted_n + 1;
         end
      end
   end

   initial begin
      int dom;
      int k;
      int m;
      int i;
      int j;
      int tmp;
      int target;
      bit full;
      logic [31:0] base;
      int order [64];
      for (i = 0; i < 2; i++) begin
         for (j = 0; j < DOMAINS; j++) begin
            done_cnt[i][j] = '0;
            early[i][j] = '0;
         end
         closed_seen[i] = 1'b0;
         run_ok[i] = 1'b1;
      end

      queue_beat(ect_pkg::CMD_CHECK, 0, 32'd0, 1'b0);
      queue_beat(ect_pkg::CMD_CHECK, 0, 32'd1, 1'b1);
      queue_beat(ect_pkg::CMD_COMPLETE, 0, 32'd0, 1'b0);
      queue_beat(ect_pkg::CMD_COMPLETE, 0, 32'd1, 1'b1);
      queue_beat(ect_pkg::CMD_COMPLETE, 0, 32'd3, 1'b0);
      queue_beat(ect_pkg::CMD_COMPLETE, 0, 32'd3, 1'b0);
      queue_beat(ect_pkg::CMD_COMPLETE, 0, 32'd65, 1'b0);
      queue_beat(ect_pkg::CMD_COMPLETE, 0, 32'd66, 1'b0);
      queue_beat(ect_pkg::CMD_COMPLETE, 0, 32'hFFFF_FFFF, 1'b1);
      queue_beat(ect_pkg::CMD_COMPLETE, 0, 32'd2, 1'b0);
      queue_beat(ect_pkg::CMD_COMPLETE, 15, 32'd1, 1'b0);
      queue_beat(ect_pkg::CMD_COMPLETE, 15, 32'd2, 1'b0);
      queue_beat(ect_pkg::CMD_CHECK, 15, 32'd2, 1'b0);
      queue_beat(ect_pkg::CMD_CHECK, 0, 32'd3, 1'b1);
      queue_beat(CMD_UNUSED, 7, 32'hFFFF_FFFF, 1'b1);
      queue_beat(ect_pkg::CMD_CHECK, 7, 32'hFFFF_FFFF, 1'b1);
      queue_beat(ect_pkg::CMD_COMPLETE, 9, 32'h8000_0000, 1'b0);
      queue_beat(ect_pkg::CMD_CHECK, 0, 32'd0, 1'b0);
      queue_beat(ect_pkg::CMD_CHECK, 3, 32'h5555_5555, 1'b0);
      queue_beat(ect_pkg::CMD_CHECK, 8, 32'hAAAA_AAAA, 1'b1);

      queue_pause();
      target = total_n + RANDOM_BEATS;
      while (total_n < target) begin
         if ($urandom_range(0, 399) == 0) queue_pause();
         if ($urandom_range(0, 99) < 35) begin
            dom = $urandom_range(0, DOMAINS - 1);
            full = ($urandom_range(0, 14) == 0);
            k = full ? WINDOW : $urandom_range(2, 12);
            base = done_cnt[GEN][dom];
            for (i = 0; i < k; i++) order[i] = i + 1;
            if (full) begin
               order[0] = k;
               order[k - 1] = 1;
            end
            m = full ? k - 1 : k;
            for (i = m - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            for (i = 0; i < k; i++)
               queue_beat(ect_pkg::CMD_COMPLETE, dom, base + 32'(order[i]),
                          1'($urandom_range(0, 1)));
         end else begin
            queue_random_beat();
         end
      end

      queue_pause();
      dom = $urandom_range(0, DOMAINS - 1);
      queue_beat(ect_pkg::CMD_CHECK, dom, 32'd0, 1'b0);
      queue_beat(ect_pkg::CMD_CLOSE, dom, $urandom(), 1'b1);
      queue_beat(ect_pkg::CMD_CHECK, dom, 32'd0, 1'b0);
      queue_beat(ect_pkg::CMD_COMPLETE, dom, done_cnt[GEN][dom] + 1, 1'b0);
      queue_beat(ect_pkg::CMD_CHECK, DOMAINS - 1 - dom, 32'd0, 1'b1);
      queue_beat(CMD_UNUSED, dom, 32'd0, 1'b0);
      queue_beat(ect_pkg::CMD_CLOSE, DOMAINS - 1 - dom, 32'hFFFF_FFFF, 1'b0);
      for (i = 0; i < 20; i++) queue_random_beat();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (accepted_n != total_n || returned_n != accepted_n) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && returned_n == accepted_n)
         $display("tb_epoch_completion_tracker_unit passed");
      else
         $display("tb_epoch_completion_tracker_unit failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_epoch_completion_tracker_unit failed");
      $finish;
   end

endmodule

[filelist.f]
hdl/ect_pkg.sv
hdl/ect_front.sv
hdl/ect_back.sv
hdl/epoch_completion_tracker_unit.sv
hdl/ect_checker.sv
bench/tb_epoch_completion_tracker_unit.sv
